[rtl/crc16_packet_deframer_macros.svh]
// Assertion macros shared by the packet deframer RTL.
// Users must provide clk and rst (synchronous, active high) in scope.
`ifndef CRC16_PACKET_DEFRAMER_MACROS_SVH
`define CRC16_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CRCPD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CRCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/crcpd_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the packet deframer.
// No dependencies; used by crcpd_core and crc16_packet_deframer.
package crcpd_pkg;

  // Frame layout and limits.
  localparam int unsigned MAX_PAYLOAD    = 1024;
  localparam int unsigned HEADER_LEN     = 8;
  localparam int unsigned FRAME_OVERHEAD = 10;
  localparam logic [10:0] POS_LIMIT      = 11'd2047;

  // CRC-16, reflected polynomial.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] CFG_VERSION      = 2'd2;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_MAGIC        = 3'd2,
    ST_VERSION      = 3'd3,
    ST_TOO_LONG     = 3'd4,
    ST_LEN_MISMATCH = 3'd5,
    ST_CRC          = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] protocol_version;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        frame_ok;
    status_t     status;
    logic [7:0]  packet_type;
    logic [15:0] sequence_number;
    logic [10:0] payload_count;
  } res_t;

  // One byte of the reflected CRC-16, unrolled over eight bit steps.
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/crc16_packet_deframer.sv]
// A byte accepted from the input waits in the input register; its result, if it has
// one, goes into the output register when that byte advances. Throughput: one byte
// per cycle while the output is not held, set by the combinational CRC update. Input
// and output registers decouple the two stream sides; a held result stalls input
// only once the input register is also full. Reset (rst, synchronous, active high)
// clears both stages, the frame state and the configuration registers.
`include "crc16_packet_deframer_macros.svh"

module crc16_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_frame
  // Results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] frame_ok, [11:9] status, [19:12] packet_type,
  // [35:20] sequence_number, [46:36] payload_count, [47] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser    // kind
);

  crcpd_pkg::cfg_t cfg;
  crcpd_pkg::res_t core_res;
  crcpd_pkg::res_t out_res;
  logic            core_emit;
  logic            in_valid;
  logic [7:0]      in_byte;
  logic            in_last;
  logic            out_valid;
  logic            advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crcpd_pkg::CFG_MAGIC_FIRST:  cfg.magic_first      <= cfg_data;
        crcpd_pkg::CFG_MAGIC_SECOND: cfg.magic_second     <= cfg_data;
        crcpd_pkg::CFG_VERSION:      cfg.protocol_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake between the two stages.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  crcpd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last      (in_last),
    .cfg       (cfg),
    .emit      (core_emit),
    .res       (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= core_emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_emit) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {1'b0, out_res.payload_count, out_res.sequence_number,
                          out_res.packet_type, out_res.status, out_res.frame_ok,
                          out_res.payload_byte};

  // Checks on the staging and the result fields.
  `CRCPD_ASSERT(a_ok_is_verdict, out_valid && out_res.frame_ok, out_res.status == crcpd_pkg::ST_OK && out_res.kind == crcpd_pkg::KIND_VERDICT, "frame_ok on a non-ok result")
  `CRCPD_ASSERT(a_payload_clean, out_valid && out_res.kind == crcpd_pkg::KIND_PAYLOAD, !out_res.frame_ok && out_res.status == crcpd_pkg::ST_OK, "payload result carries verdict fields")
  `CRCPD_ASSERT_NEXT(a_input_held, in_valid && !advance, in_valid && in_byte == $past(in_byte) && in_last == $past(in_last), "stalled input byte lost")

endmodule

[rtl/crcpd_core.sv]
// Frame checker: position count, running CRC, header capture and verdict.
// Depends on crcpd_pkg and crc16_packet_deframer_macros.svh.
`include "crc16_packet_deframer_macros.svh"

module crcpd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               last,
  input  crcpd_pkg::cfg_t    cfg,
  output logic               emit,
  output crcpd_pkg::res_t    res
);

  logic [10:0] byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic        magic_error, magic_error_next;
  logic        version_error, version_error_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_sequence, held_sequence_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] received_crc, received_crc_next;

  logic [16:0] pos_ext;
  logic [16:0] pay_end;
  logic [16:0] size_ext;
  logic        in_header;
  logic        in_payload;
  crcpd_pkg::status_t status;

  // Position decode against the payload window.
  assign pos_ext    = {6'd0, byte_position};
  assign pay_end    = 17'(crcpd_pkg::HEADER_LEN) + {1'b0, held_length};
  assign size_ext   = pos_ext + 17'd1;
  assign in_header  = pos_ext < 17'(crcpd_pkg::HEADER_LEN);
  assign in_payload = !in_header && (pos_ext < pay_end);

  // Next frame state for the byte being stepped.
  always_comb begin
    magic_error_next   = magic_error;
    version_error_next = version_error;
    held_type_next     = held_type;
    held_sequence_next = held_sequence;
    held_length_next   = held_length;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;

    unique case (byte_position)
      11'd0: if (data_byte != cfg.magic_first) magic_error_next = 1'b1;
      11'd1: if (data_byte != cfg.magic_second) magic_error_next = 1'b1;
      11'd2: if (data_byte != cfg.protocol_version) version_error_next = 1'b1;
      11'd3: held_type_next = data_byte;
      11'd4: held_sequence_next[7:0] = data_byte;
      11'd5: held_sequence_next[15:8] = data_byte;
      11'd6: held_length_next[7:0] = data_byte;
      11'd7: held_length_next[15:8] = data_byte;
      default: ;
    endcase

    if (in_header || in_payload) begin
      running_crc_next = crcpd_pkg::crc_update(running_crc, data_byte);
    end else if (pos_ext == pay_end) begin
      received_crc_next[7:0] = data_byte;
    end else if (pos_ext == pay_end + 17'd1) begin
      received_crc_next[15:8] = data_byte;
    end

    byte_position_next = (byte_position != crcpd_pkg::POS_LIMIT) ?
                         byte_position + 11'd1 : byte_position;
  end

  // Verdict: first failing check wins. The checks see the last byte's own updates,
  // so a final CRC byte is compared with everything before it.
  always_comb begin
    if (size_ext < 17'(crcpd_pkg::FRAME_OVERHEAD)) begin
      status = crcpd_pkg::ST_SHORT;
    end else if (magic_error_next) begin
      status = crcpd_pkg::ST_MAGIC;
    end else if (version_error_next) begin
      status = crcpd_pkg::ST_VERSION;
    end else if (held_length_next > 16'(crcpd_pkg::MAX_PAYLOAD)) begin
      status = crcpd_pkg::ST_TOO_LONG;
    end else if (size_ext !=
                 17'(crcpd_pkg::FRAME_OVERHEAD) + {1'b0, held_length_next}) begin
      status = crcpd_pkg::ST_LEN_MISMATCH;
    end else if (received_crc_next != running_crc_next) begin
      status = crcpd_pkg::ST_CRC;
    end else begin
      status = crcpd_pkg::ST_OK;
    end
  end

  // Result for this byte: a verdict on the last byte, a pass-through for a payload byte, else none.
  always_comb begin
    res  = '0;
    emit = 1'b0;
    if (step && last) begin
      emit       = 1'b1;
      res.kind   = crcpd_pkg::KIND_VERDICT;
      res.status = status;
      if (status == crcpd_pkg::ST_OK) begin
        res.frame_ok        = 1'b1;
        res.packet_type     = held_type;
        res.sequence_number = held_sequence;
        res.payload_count   = held_length[10:0];
      end
    end else if (step && in_payload) begin
      emit             = 1'b1;
      res.kind         = crcpd_pkg::KIND_PAYLOAD;
      res.payload_byte = data_byte;
    end
  end

  // Frame state; the last byte returns it to its reset values.
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_position <= '0;
      running_crc   <= crcpd_pkg::CRC_INIT;
      magic_error   <= 1'b0;
      version_error <= 1'b0;
      held_type     <= '0;
      held_sequence <= '0;
      held_length   <= '0;
      received_crc  <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      magic_error   <= magic_error_next;
      version_error <= version_error_next;
      held_type     <= held_type_next;
      held_sequence <= held_sequence_next;
      held_length   <= held_length_next;
      received_crc  <= received_crc_next;
    end
  end

  // Checks on the frame state.
  `CRCPD_ASSERT_NEXT(a_clear_after_last, step && last, byte_position == 11'd0 && running_crc == crcpd_pkg::CRC_INIT, "frame state not cleared after last byte")
  `CRCPD_ASSERT_NEXT(a_pos_count, step && !last && byte_position != crcpd_pkg::POS_LIMIT, byte_position == $past(byte_position) + 11'd1, "byte position did not advance")
  `CRCPD_ASSERT(a_emit_needs_step, !step, !emit, "result emitted without a byte")

endmodule
